FILE: sv/assert_macros.svh
// assertion macros shared by the rtl files
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define SADI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define SADI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SADI_ASSERT(lbl, prop, msg)
`define SADI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/sadi_pkg.sv
// shared constants, op and status codes and the controller to datapath command
// no dependencies
`timescale 1ns / 1ps
package sadi_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = 6;
    localparam int WORD_W      = 32;
    localparam int LEN_W       = 5;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    // width that holds both a nonnegative position and the count
    localparam int CMP_W       = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

    typedef enum logic [OP_W-1:0] {
        OP_READ     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_INSERT   = 3'd2,
        OP_DELETE   = 3'd3,
        OP_TRUNCATE = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic take;
    } t_dp_cmd;
endpackage

FILE: sv/sadi_ctrl.sv
// handshake controller: accepts a request when the result slot is free or draining
// depends on sadi_pkg
`timescale 1ns / 1ps
module sadi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sadi_pkg::t_dp_cmd o_cmd
);
    import sadi_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   w_take;

    // held off during reset and while a result waits on a stalled consumer
    assign o_in_stall  = !i_rst_n || (r_state == S_HOLD && i_out_stall);
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_HOLD);
    assign o_cmd.take  = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            unique case (r_state)
                S_EMPTY: begin
                    if (w_take) r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (w_take) r_state <= S_HOLD;
                    else if (!i_out_stall) r_state <= S_EMPTY;
                end
                default: r_state <= S_EMPTY;
            endcase
        end
    end
endmodule

FILE: sv/sadi_dp.sv
// datapath: register cells with parallel shift, length counter, result registers
// depends on sadi_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sadi_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sadi_pkg::t_dp_cmd                  i_cmd,
    input  logic [sadi_pkg::OP_W-1:0]          i_op,
    input  logic signed [sadi_pkg::POS_W-1:0]  i_position,
    input  logic signed [sadi_pkg::WORD_W-1:0] i_item_value,
    output logic signed [sadi_pkg::WORD_W-1:0] o_read_value,
    output logic [sadi_pkg::LEN_W-1:0]         o_length_now,
    output logic [sadi_pkg::ST_W-1:0]          o_status
);
    import sadi_pkg::*;

    t_word              r_cells [MAX_ENTRIES];
    t_word              n_cells [MAX_ENTRIES];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_word              r_read;
    t_word              n_read;
    t_status            r_status;
    t_status            n_status;

    logic               w_neg;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_len;
    logic [CMP_W-1:0]   w_ins;
    logic               w_in_range;
    logic               w_full;

    assign w_neg      = i_position[POS_W-1];
    assign w_pos      = CMP_W'(unsigned'(i_position[POS_W-2:0]));
    assign w_len      = CMP_W'(r_count);
    assign w_in_range = !w_neg && (w_pos < w_len);
    assign w_full     = (r_count == CNT_W'(MAX_ENTRIES));
    // insert position clamped into 0..length
    assign w_ins      = w_neg ? '0 : ((w_pos > w_len) ? w_len : w_pos);

    always_comb begin
        n_cells  = r_cells;
        n_count  = r_count;
        n_read   = '0;
        n_status = ST_DONE;
        unique case (t_op'(i_op))
            OP_READ: begin
                if (w_in_range) n_read = r_cells[w_pos[IDX_W-1:0]];
                else n_status = ST_RANGE;
            end
            OP_WRITE: begin
                if (w_in_range) n_cells[w_pos[IDX_W-1:0]] = i_item_value;
                else n_status = ST_RANGE;
            end
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    // every cell above the slot takes its lower neighbor
                    for (int k = 1; k < MAX_ENTRIES; k++) begin
                        if (CMP_W'(k) > w_ins) n_cells[k] = r_cells[k-1];
                    end
                    n_cells[w_ins[IDX_W-1:0]] = i_item_value;
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_in_range) begin
                    for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
                        if (CMP_W'(k) >= w_pos) n_cells[k] = r_cells[k+1];
                    end
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            OP_TRUNCATE: begin
                if (!w_neg && w_pos <= w_len) n_count = CNT_W'(w_pos);
                else n_status = ST_RANGE;
            end
            default: n_status = ST_RANGE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cells  <= n_cells;
            r_read   <= n_read;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.take) begin
            r_count <= n_count;
        end
    end

    assign o_read_value = r_read;
    assign o_length_now = LEN_W'(r_count);
    assign o_status     = r_status;

    `SADI_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_ENTRIES), "length above capacity")
    `SADI_ASSERT_NEXT(a_count_idle, !i_cmd.take, $stable(r_count), "length moved without request")
    `SADI_ASSERT_NEXT(a_insert_grows, i_cmd.take && i_op == OP_INSERT && !w_full, r_count == CNT_W'($past(r_count) + 1'b1), "insert did not grow length")
    `SADI_ASSERT_NEXT(a_delete_shrinks, i_cmd.take && i_op == OP_DELETE && w_in_range, r_count == CNT_W'($past(r_count) - 1'b1), "delete did not shrink length")
endmodule

FILE: sv/shifting_array_insert_delete.sv
// Ordered store of up to sadi_pkg::MAX_ENTRIES signed words with a length. One request
// is taken per clock cycle while o_in_stall is low; its result appears on the output
// registers the cycle after acceptance and stays until taken. Insert and delete finish
// at acceptance since every register cell loads from its neighbor in parallel; the
// cell shift network and the length compare set the cycle. A new request is accepted
// while a result is pending as long as the consumer is not stalling; otherwise
// o_in_stall follows i_out_stall; it is high in reset. Reads past the length give 0.
// top level: joins sadi_ctrl and sadi_dp, depends on sadi_pkg
`timescale 1ns / 1ps
module shifting_array_insert_delete (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [sadi_pkg::OP_W-1:0]          i_op,
    input  logic signed [sadi_pkg::POS_W-1:0]  i_position,
    input  logic signed [sadi_pkg::WORD_W-1:0] i_item_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [sadi_pkg::WORD_W-1:0] o_read_value,
    output logic [sadi_pkg::LEN_W-1:0]         o_length_now,
    output logic [sadi_pkg::ST_W-1:0]          o_status
);
    import sadi_pkg::*;

    t_dp_cmd w_cmd;

    sadi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    sadi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_read_value (o_read_value),
        .o_length_now (o_length_now),
        .o_status     (o_status)
    );
endmodule

FILE: tb/sadi_result_checker.sv
// result checker for shifting_array_insert_delete: tracks a shadow copy of the store
// and compares every result against the oldest outstanding prediction; uses sadi_pkg
`timescale 1ns / 1ps
module sadi_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [sadi_pkg::OP_W-1:0]          i_op,
    input  logic signed [sadi_pkg::POS_W-1:0]  i_position,
    input  sadi_pkg::t_word                    i_item_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  sadi_pkg::t_word                    i_read_value,
    input  logic [sadi_pkg::LEN_W-1:0]         i_length_now,
    input  logic [sadi_pkg::ST_W-1:0]          i_status,
    output int                                 o_errors,
    output int                                 o_waiting,
    output int                                 o_stored_count
);
    import sadi_pkg::*;

    typedef struct packed {
        t_word             rd;
        logic [LEN_W-1:0]  len;
        t_status           st;
    } t_outcome;

    t_word    shadow [MAX_ENTRIES];
    int       shadow_len = 0;
    int       errors = 0;
    int       due_count = 0;
    t_outcome results_due [$];

    assign o_errors       = errors;
    assign o_waiting      = due_count;
    assign o_stored_count = shadow_len;

    // applies one request to the shadow store and returns the result it should give
    function automatic t_outcome predict_outcome(input logic [OP_W-1:0] code,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input t_word word);
        t_outcome res;
        int       p;
        int       k;
        res.rd = '0;
        res.st = ST_DONE;
        p = pos;
        case (code)
            OP_READ: begin
                if (p >= 0 && p < shadow_len) res.rd = shadow[p];
                else res.st = ST_RANGE;
            end
            OP_WRITE: begin
                if (p >= 0 && p < shadow_len) shadow[p] = word;
                else res.st = ST_RANGE;
            end
            OP_INSERT: begin
                if (shadow_len >= MAX_ENTRIES) begin
                    res.st = ST_FULL;
                end else begin
                    // position is clamped into 0..length, above length appends
                    if (p > shadow_len) p = shadow_len;
                    else if (p < 0) p = 0;
                    for (k = shadow_len; k > p; k--) shadow[k] = shadow[k-1];
                    shadow[p] = word;
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (p >= 0 && p < shadow_len) begin
                    for (k = p; k < shadow_len - 1; k++) shadow[k] = shadow[k+1];
                    shadow_len--;
                end else begin
                    res.st = ST_RANGE;
                end
            end
            OP_TRUNCATE: begin
                if (p >= 0 && p <= shadow_len) shadow_len = p;
                else res.st = ST_RANGE;
            end
            default: res.st = ST_RANGE;
        endcase
        res.len = shadow_len[LEN_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome due;
        if (i_rst_n) begin
            // results leave before the same edge's request is predicted
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("unrequested result: read_value %0d length_now %0d status %0d",
                           i_read_value, i_length_now, i_status);
                    errors++;
                end else begin
                    due = results_due.pop_front();
                    if (i_read_value !== due.rd) begin
                        $error("read_value: expected %0d, got %0d", due.rd, i_read_value);
                        errors++;
                    end
                    if (i_length_now !== due.len) begin
                        $error("length_now: expected %0d, got %0d", due.len, i_length_now);
                        errors++;
                    end
                    if (i_status !== due.st) begin
                        $error("status: expected %0d, got %0d", due.st, i_status);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(predict_outcome(i_op, i_position, i_item_value));
            due_count = results_due.size();
        end
    end
endmodule

FILE: tb/shifting_array_insert_delete_tb.sv
// top of the shifting_array_insert_delete testbench: clock, reset, request stimulus,
// output stall pattern and verdict; depends on sadi_pkg and sadi_result_checker
`timescale 1ns / 1ps
module shifting_array_insert_delete_tb;
    import sadi_pkg::*;

    localparam int    TOTAL_REQUESTS = 1950;
    localparam int    CALM_TAIL      = 200;
    localparam int    HOLD_AT        = 600;
    localparam int    PAUSE_AT       = 1100;
    localparam int    LONG_HOLD      = 80;
    localparam int    MAX_GAP        = 13;
    localparam int    IDLE_LIMIT     = 2000;
    localparam int    OP_CODES       = 1 << OP_W;
    localparam t_word WORD_MIN       = 32'sh8000_0000;
    localparam t_word WORD_MAX       = 32'sh7FFF_FFFF;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] position;
    t_word                   item_value;
    logic                    out_valid;
    logic                    out_stall;
    t_word                   read_value;
    logic [LEN_W-1:0]        length_now;
    logic [ST_W-1:0]         status;

    int errors;
    int waiting;
    int stored;
    int sent = 0;
    int idle_cycles = 0;
    int op_tally [OP_CODES] = '{default: 0};
    bit calm = 1'b0;
    bit hold_wanted = 1'b0;
    bit send_bursty = 1'b1;
    bit recv_bursty = 1'b1;

    shifting_array_insert_delete dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_op         (op),
        .i_position   (position),
        .i_item_value (item_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_read_value (read_value),
        .o_length_now (length_now),
        .o_status     (status)
    );

    sadi_result_checker result_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_op           (op),
        .i_position     (position),
        .i_item_value   (item_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_read_value   (read_value),
        .i_length_now   (length_now),
        .i_status       (status),
        .o_errors       (errors),
        .o_waiting      (waiting),
        .o_stored_count (stored)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // watchdog on cycles where neither channel moves
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL shifting_array_insert_delete");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 11))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // mostly a valid index, sometimes just past the end or anywhere in the field
    function automatic int aim_position(input int limit);
        case ($urandom_range(0, 9))
            0: return limit;
            1: return span(-32, -1);
            2: return span(0, 31);
            default: return (limit > 0) ? span(0, limit - 1) : 0;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(input logic [OP_W-1:0] code, input int pos, input t_word word);
        calm = (sent >= TOTAL_REQUESTS - CALM_TAIL);
        if ($urandom_range(0, 99) == 0) send_bursty = !send_bursty;
        if (sent == HOLD_AT) hold_wanted = 1'b1;
        if (sent == PAUSE_AT) begin
            // drain everything before going on
            in_valid <= 1'b0;
            @(negedge clk);
            while (waiting != 0) @(negedge clk);
        end else if (!calm && send_bursty && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        position   <= pos[POS_W-1:0];
        item_value <= word;
        do @(posedge clk); while (in_stall);
        sent++;
        op_tally[code]++;
        @(negedge clk);
    endtask

    task automatic fill_store();
        while (stored < MAX_ENTRIES) issue(OP_INSERT, span(-3, stored + 3), pick_word());
        // inserts that find the store full
        repeat ($urandom_range(1, 2)) issue(OP_INSERT, span(-32, 31), pick_word());
    endtask

    task automatic drain_store();
        while (stored > 0) issue(OP_DELETE, span(0, stored - 1), pick_word());
        issue(OP_DELETE, aim_position(stored), pick_word());
    endtask

    task automatic mixed_traffic();
        repeat ($urandom_range(20, 60)) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:  issue(OP_READ, aim_position(stored), pick_word());
                6, 7, 8, 9:        issue(OP_WRITE, aim_position(stored), pick_word());
                10, 11, 12, 13, 14: issue(OP_INSERT, span(-2, stored + 2), pick_word());
                15, 16, 17, 18:    issue(OP_DELETE, aim_position(stored), pick_word());
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        issue(OP_TRUNCATE, span(-32, 31), pick_word());
                    else
                        issue(OP_TRUNCATE, span(stored - 2, stored), pick_word());
                end
            endcase
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(5, 20))
            issue(OP_W'($urandom_range(0, OP_CODES - 1)), span(-32, 31), $urandom);
    endtask

    // output side stall pattern, including one long hold
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0) recv_bursty = !recv_bursty;
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (!calm && recv_bursty && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, MAX_GAP) - 1) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_READ;
        position   = '0;
        item_value = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store: everything out of range except truncate to zero
        issue(OP_READ, 0, '0);
        issue(OP_WRITE, 0, WORD_MAX);
        issue(OP_DELETE, 0, '0);
        issue(OP_TRUNCATE, 1, '0);
        issue(OP_TRUNCATE, 0, '0);
        for (int c = OP_TRUNCATE + 1; c < OP_CODES; c++)
            issue(OP_W'(c), span(-32, 31), $urandom);
        // clamped inserts at both ends, then a middle and a front insert
        issue(OP_INSERT, -32, WORD_MAX);
        issue(OP_INSERT, 31, WORD_MIN);
        issue(OP_INSERT, 1, -1);
        issue(OP_INSERT, 0, '0);
        issue(OP_READ, 0, '0);
        issue(OP_READ, 3, '0);
        issue(OP_READ, 4, '0);
        issue(OP_READ, -1, '0);
        issue(OP_WRITE, 3, 32'sh5555_5555);
        issue(OP_WRITE, 4, WORD_MIN);
        issue(OP_DELETE, 1, '0);
        issue(OP_DELETE, 3, '0);
        issue(OP_DELETE, -1, '0);
        issue(OP_TRUNCATE, 4, '0);
        issue(OP_TRUNCATE, 3, '0);
        issue(OP_TRUNCATE, 1, '0);

        fill_store();
        while (sent < TOTAL_REQUESTS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:  fill_store();
                5, 6, 7:        drain_store();
                8, 9, 10:       noise_burst();
                default:        mixed_traffic();
            endcase
        end

        in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        $display("%0d requests: %0d read, %0d write, %0d insert, %0d delete, %0d truncate",
                 sent, op_tally[OP_READ], op_tally[OP_WRITE], op_tally[OP_INSERT],
                 op_tally[OP_DELETE], op_tally[OP_TRUNCATE]);
        $display("%0d with unused op codes, %0d field mismatches",
                 sent - op_tally[OP_READ] - op_tally[OP_WRITE] - op_tally[OP_INSERT]
                 - op_tally[OP_DELETE] - op_tally[OP_TRUNCATE], errors);
        if (errors == 0)
            $display("PASS shifting_array_insert_delete");
        else
            $display("FAIL shifting_array_insert_delete");
        $finish;
    end
endmodule
